/* rtl/look_disk_scheduler_core_assert.svh */
// Assertion macros for the LOOK disk scheduler checker.
// Included by lkds_checker.sv; needs nothing else.
`ifndef LOOK_DISK_SCHEDULER_CORE_ASSERT_SVH
`define LOOK_DISK_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LKDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LKDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lkds_pkg.sv */
// Shared types and codes for the LOOK disk scheduler.
// No dependencies.
`default_nettype none

package lkds_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

/* rtl/lkds_req_mem.sv */
// Request store: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module lkds_req_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 12,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/look_disk_scheduler_core.sv */
// LOOK disk scheduler: load requests into a queue, then sweep them out in LOOK order.
// Uses lkds_pkg and lkds_req_mem.
//
// Slave channel: a transfer with tuser = load appends tdata's cylinder to the
// queue (dropped when the queue is full); tuser = start gives the head cylinder
// and the first sweep direction and runs one schedule.
// Master channel: one transfer per served request with its cylinder and the
// running seek total; tlast marks the final one. A start on an empty queue
// gives a single result holding the head with seek zero.
// Loads are taken back to back while no schedule runs. During a schedule each
// result costs one full scan of the request memory, then a load of the output
// register, plus one extra scan when the sweep turns; the single read port
// makes each scan read the queued requests one by one.
// The slave side is not ready from a start until the final result is loaded
// into the output register. An empty start skips the scan and goes straight to output.
// Reset empties the queue at once; the store needs no clearing pass.
// When the receiver stalls, the output register holds and the scan waits.
`default_nettype none

module look_disk_scheduler_core #(
    parameter int QUEUE_DEPTH = 32,
    parameter int CYL_BITS    = 12
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_s_tvalid,
    output logic                                            o_s_tready,
    // [CYL_BITS-1:0] cylinder, [CYL_BITS] direction, zero fill above
    input  wire logic [((CYL_BITS + 1 + 7) / 8) * 8 - 1:0]  i_s_tdata,
    // [0] command
    input  wire logic                                       i_s_tuser,
    output logic                                            o_m_tvalid,
    input  wire logic                                       i_m_tready,
    // [CYL_BITS-1:0] served_cylinder, [2*CYL_BITS:CYL_BITS] total_seek, zero fill
    output logic      [((2 * CYL_BITS + 1 + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic                                            o_m_tlast
);

    localparam int SEEK_BITS = CYL_BITS + 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OUT_W     = ((2 * CYL_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_PAD   = OUT_W - CYL_BITS - SEEK_BITS;

    lkds_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_nserved;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_found;
    logic [CYL_BITS-1:0]    r_best;
    logic [IDX_W-1:0]       r_best_idx;
    logic [QUEUE_DEPTH-1:0] r_mark;
    logic                   r_phase;
    logic                   r_dir;
    logic [CYL_BITS-1:0]    r_start;
    logic [CYL_BITS-1:0]    r_head;
    logic [SEEK_BITS-1:0]   r_seek;
    logic                   r_emit_last;
    logic                   r_out_vld;
    logic [CYL_BITS-1:0]    r_out_cyl;
    logic [SEEK_BITS-1:0]   r_out_seek;
    logic                   r_out_last;

    logic                   s_ready;
    logic                   s_acc;
    logic                   is_start;
    logic                   mem_wr_en;
    logic                   mem_rd_en;
    logic                   out_free;
    logic                   out_load;
    logic                   scan_done;
    logic [CYL_BITS-1:0]    in_cyl;
    logic                   in_dir;
    logic [CYL_BITS-1:0]    rd_v;
    logic                   cur_upper;
    logic                   in_grp;
    logic                   better;
    logic                   take;
    logic [CYL_BITS-1:0]    seek_step;
    logic [SEEK_BITS-1:0]   seek_nxt;
    logic [CNT_W-1:0]       nserved_nxt;

    assign in_cyl   = i_s_tdata[CYL_BITS-1:0];
    assign in_dir   = i_s_tdata[CYL_BITS];
    assign s_acc    = i_s_tvalid && s_ready;
    assign is_start = (i_s_tuser == lkds_pkg::CMD_START);
    assign out_free = !r_out_vld || i_m_tready;
    assign mem_wr_en = s_acc && !is_start && (r_count < CNT_W'(QUEUE_DEPTH));

    lkds_req_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CYL_BITS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (in_cyl),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_v)
    );

    assign cur_upper = r_phase ? !r_dir : r_dir;
    assign in_grp    = cur_upper ? (rd_v > r_start) : (rd_v <= r_start);
    assign better    = !r_found || (cur_upper ? (rd_v < r_best) : (rd_v > r_best));
    assign take      = r_rd_vld && !r_mark[r_rd_idx] && in_grp && better;
    assign seek_step = (r_best >= r_head) ? (r_best - r_head) : (r_head - r_best);
    assign seek_nxt  = r_seek + {1'b0, seek_step};
    assign nserved_nxt = r_nserved + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lkds_pkg::ST_IDLE: begin
                if (s_acc && is_start) begin
                    n_state = (r_count == '0) ? lkds_pkg::ST_OUT : lkds_pkg::ST_SCAN;
                end
            end
            lkds_pkg::ST_SCAN: begin
                if (scan_done) begin
                    if (r_found) begin
                        n_state = lkds_pkg::ST_OUT;
                    end else if (r_phase) begin
                        n_state = lkds_pkg::ST_IDLE;
                    end
                end
            end
            lkds_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = r_emit_last ? lkds_pkg::ST_IDLE : lkds_pkg::ST_SCAN;
                end
            end
            default: n_state = lkds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        mem_rd_en = 1'b0;
        scan_done = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            lkds_pkg::ST_IDLE: s_ready = 1'b1;
            lkds_pkg::ST_SCAN: begin
                mem_rd_en = (r_idx < r_count);
                scan_done = (r_idx == r_count) && !r_rd_vld;
            end
            lkds_pkg::ST_OUT: out_load = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkds_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_nserved   <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_mark      <= '0;
            r_phase     <= 1'b0;
            r_head      <= '0;
            r_seek      <= '0;
            r_emit_last <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_rd_en;
            if (mem_rd_en) begin
                r_rd_idx <= r_idx[IDX_W-1:0];
                r_idx    <= r_idx + CNT_W'(1);
            end
            if (take) begin
                r_found    <= 1'b1;
                r_best     <= rd_v;
                r_best_idx <= r_rd_idx;
            end
            if (mem_wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (s_acc && is_start) begin
                r_start     <= in_cyl;
                r_head      <= in_cyl;
                r_seek      <= '0;
                r_dir       <= in_dir;
                r_phase     <= 1'b0;
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_nserved   <= '0;
                r_emit_last <= (r_count == '0);
            end
            if (scan_done) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                if (r_found) begin
                    r_mark[r_best_idx] <= 1'b1;
                    r_head             <= r_best;
                    r_seek             <= seek_nxt;
                    r_nserved          <= nserved_nxt;
                    r_emit_last        <= (nserved_nxt == r_count);
                end else if (r_phase) begin
                    r_count <= '0;
                    r_mark  <= '0;
                end else begin
                    r_phase <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_out_cyl  <= r_head;
                r_out_seek <= r_seek;
                r_out_last <= r_emit_last;
                if (r_emit_last) begin
                    r_count <= '0;
                    r_mark  <= '0;
                end
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{OUT_PAD{1'b0}}, r_out_seek, r_out_cyl};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

/* rtl/lkds_checker.sv */
// Port-level checks for the LOOK disk scheduler, bound to its top level.
// Uses look_disk_scheduler_core_assert.svh.
`default_nettype none

`include "look_disk_scheduler_core_assert.svh"

module lkds_checker #(
    parameter int CYL_BITS = 12
) (
    input wire logic                                          i_clk,
    input wire logic                                          i_rst_n,
    input wire logic                                          i_s_tvalid,
    input wire logic                                          o_s_tready,
    input wire logic                                          i_s_tuser,
    input wire logic                                          o_m_tvalid,
    input wire logic                                          i_m_tready,
    input wire logic [((2 * CYL_BITS + 1 + 7) / 8) * 8 - 1:0] o_m_tdata,
    input wire logic                                          o_m_tlast
);

    `LKDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")

    `LKDS_ASSERT_NOW(a_busy_mid_run, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, !o_s_tready, "input ready while a schedule is still running")

    `LKDS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser, !o_s_tready, "input ready right after a start")

endmodule

bind look_disk_scheduler_core lkds_checker #(
    .CYL_BITS (CYL_BITS)
) u_lkds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

/* tb/tb_look_disk_scheduler_core.sv */
// Self-checking testbench for look_disk_scheduler_core: predicts LOOK service order and
// running seek totals for each start transfer and checks every master transfer in order.
// Depends on lkds_pkg and the look_disk_scheduler_core RTL only.
`timescale 1ns / 100ps

module tb_look_disk_scheduler_core;

    localparam int QDEPTH = 32;
    localparam int CYL_W  = 12;
    localparam int SEEK_W = CYL_W + 1;

    typedef struct packed {
        logic [CYL_W-1:0]  cyl;
        logic [SEEK_W-1:0] seek;
        logic              is_last;
    } t_served_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;

    look_disk_scheduler_core #(
        .QUEUE_DEPTH(QDEPTH),
        .CYL_BITS   (CYL_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    logic [CYL_W-1:0] pending_cyl [QDEPTH];
    int               pending_count = 0;
    t_served_req      service_order [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int mismatch_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("look_disk_scheduler_core test failed");
        $finish;
    end

    function automatic void record_load(logic [CYL_W-1:0] cyl);
        if (pending_count < QDEPTH) begin
            pending_cyl[pending_count] = cyl;
            pending_count++;
        end
    endfunction

    function automatic void predict_schedule(logic [CYL_W-1:0] head, logic up_first);
        bit                served [QDEPTH];
        logic [CYL_W-1:0]  pos;
        logic [SEEK_W-1:0] seek;
        t_served_req       prev;
        bit                have_prev;
        bit                upper;
        int                best;
        pos       = head;
        seek      = '0;
        have_prev = 1'b0;
        prev      = '0;
        for (int i = 0; i < QDEPTH; i++) served[i] = 1'b0;
        for (int pass = 0; pass < 2; pass++) begin
            upper = (pass == 0) ? up_first : !up_first;
            do begin
                best = -1;
                for (int i = 0; i < pending_count; i++) begin
                    if (!served[i] && (upper ? (pending_cyl[i] > head)
                                             : (pending_cyl[i] <= head))) begin
                        if (best < 0 || (upper ? (pending_cyl[i] < pending_cyl[best])
                                               : (pending_cyl[i] > pending_cyl[best])))
                            best = i;
                    end
                end
                if (best >= 0) begin
                    served[best] = 1'b1;
                    seek = seek + ((pending_cyl[best] > pos) ? (pending_cyl[best] - pos)
                                                             : (pos - pending_cyl[best]));
                    pos = pending_cyl[best];
                    if (have_prev) service_order.push_back(prev);
                    prev      = t_served_req'{cyl: pos, seek: seek, is_last: 1'b0};
                    have_prev = 1'b1;
                end
            end while (best >= 0);
        end
        if (have_prev) begin
            prev.is_last = 1'b1;
            service_order.push_back(prev);
        end else begin
            service_order.push_back(t_served_req'{cyl: head, seek: '0, is_last: 1'b1});
        end
        pending_count = 0;
    endfunction

    initial begin
        int hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        t_served_req got;
        t_served_req want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = t_served_req'{cyl: o_m_tdata[CYL_W-1:0], seek: o_m_tdata[2*CYL_W:CYL_W],
                                    is_last: o_m_tlast};
                if (service_order.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: cyl=%0d seek=%0d last=%0b",
                                 got.cyl, got.seek, got.is_last);
                end else begin
                    want = service_order.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected cyl=%0d seek=%0d last=%0b, ",
                                      "got cyl=%0d seek=%0d last=%0b"},
                                     want.cyl, want.seek, want.is_last,
                                     got.cyl, got.seek, got.is_last);
                    end
                end
            end
        end
    end

    task automatic send_item(logic cmd, logic [CYL_W-1:0] cyl, logic dir);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {3'b000, dir, cyl};
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == lkds_pkg::CMD_LOAD) record_load(cyl);
        else predict_schedule(cyl, dir);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (service_order.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_random(int count);
        for (int i = 0; i < count; i++)
            send_item(lkds_pkg::CMD_LOAD, CYL_W'($urandom_range(4095)),
                      1'($urandom_range(1)));
    endtask

    task automatic test_empty_start();
        send_item(lkds_pkg::CMD_START, 12'd0, 1'b0);
        send_item(lkds_pkg::CMD_START, 12'd4095, 1'b1);
        wait_drained();
    endtask

    task automatic test_extremes();
        send_item(lkds_pkg::CMD_LOAD, 12'd4095, 1'b1);
        send_item(lkds_pkg::CMD_LOAD, 12'd0, 1'b1);
        send_item(lkds_pkg::CMD_START, 12'd0, 1'b1);
        send_item(lkds_pkg::CMD_LOAD, 12'd0, 1'b0);
        send_item(lkds_pkg::CMD_LOAD, 12'd4095, 1'b0);
        send_item(lkds_pkg::CMD_LOAD, 12'd2048, 1'b1);
        send_item(lkds_pkg::CMD_START, 12'd2048, 1'b0);
        send_item(lkds_pkg::CMD_LOAD, 12'd4095, 1'b0);
        send_item(lkds_pkg::CMD_START, 12'd4095, 1'b1);
        wait_drained();
    endtask

    task automatic test_equal_cylinders();
        send_item(lkds_pkg::CMD_LOAD, 12'd100, 1'b0);
        send_item(lkds_pkg::CMD_LOAD, 12'd100, 1'b1);
        send_item(lkds_pkg::CMD_LOAD, 12'd100, 1'b0);
        send_item(lkds_pkg::CMD_LOAD, 12'd50, 1'b0);
        send_item(lkds_pkg::CMD_START, 12'd100, 1'b1);
        send_item(lkds_pkg::CMD_LOAD, 12'd7, 1'b0);
        send_item(lkds_pkg::CMD_LOAD, 12'd7, 1'b0);
        send_item(lkds_pkg::CMD_START, 12'd3, 1'b0);
        wait_drained();
    endtask

    task automatic test_queue_full();
        load_random(QDEPTH + 3);
        send_item(lkds_pkg::CMD_START, CYL_W'($urandom_range(4095)), 1'b1);
        load_random(QDEPTH);
        send_item(lkds_pkg::CMD_START, CYL_W'($urandom_range(4095)), 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_request = 1500;
        load_random(QDEPTH + 4);
        send_item(lkds_pkg::CMD_START, CYL_W'($urandom_range(4095)), 1'b1);
        load_random(6);
        send_item(lkds_pkg::CMD_START, CYL_W'($urandom_range(4095)), 1'b0);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        load_random(5);
        send_item(lkds_pkg::CMD_START, CYL_W'($urandom_range(4095)), 1'b0);
        wait_drained();
        load_random(3);
        send_item(lkds_pkg::CMD_START, CYL_W'($urandom_range(4095)), 1'b1);
        wait_drained();
    endtask

    task automatic test_random_schedules(int item_budget);
        int               sent;
        int               nreq;
        int               pick;
        bit               narrow;
        logic [CYL_W-1:0] base;
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] head;
        sent = 0;
        while (sent < item_budget) begin
            pick   = $urandom_range(99);
            nreq   = (pick < 8) ? 0 : (pick < 13) ? $urandom_range(QDEPTH + 4, QDEPTH + 1)
                                                   : $urandom_range(12, 1);
            narrow = ($urandom_range(3) == 0);
            base   = CYL_W'($urandom_range(4095));
            cyl    = base;
            for (int i = 0; i < nreq; i++) begin
                cyl = narrow ? CYL_W'(base + $urandom_range(15)) : CYL_W'($urandom_range(4095));
                send_item(lkds_pkg::CMD_LOAD, cyl, 1'($urandom_range(1)));
            end
            head = ($urandom_range(3) == 0) ? cyl : CYL_W'($urandom_range(4095));
            send_item(lkds_pkg::CMD_START, head, 1'($urandom_range(1)));
            sent += nreq + 1;
        end
        wait_drained();
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        int guard;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = lkds_pkg::CMD_LOAD;
        i_s_tdata  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_empty_start();
        test_extremes();
        test_equal_cylinders();
        test_queue_full();
        test_backpressure();
        test_sender_pause();
        set_idling(0, 0);
        test_random_schedules(35);
        set_idling(64, 0);
        test_random_schedules(35);
        set_idling(0, 64);
        test_random_schedules(35);
        set_idling(20, 20);
        test_random_schedules(35);
        set_idling(0, 0);
        test_random_schedules(20);

        stop_sending();
        guard = 0;
        while (service_order.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        mismatch_count += service_order.size();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("look_disk_scheduler_core test passed");
        end else begin
            $display("look_disk_scheduler_core test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/lkds_pkg.sv
rtl/lkds_req_mem.sv
rtl/look_disk_scheduler_core.sv
rtl/lkds_checker.sv
tb/tb_look_disk_scheduler_core.sv
